### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define SKSR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define SKSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sksr_pkg.sv
// shared types and constants of the sorted key equal range search block
`default_nettype none

package sksr_pkg;

	// field widths
	localparam int CODE_W  = 16;
	localparam int SIZE_W  = 8;
	localparam int ADDR_W  = 32;
	localparam int INDEX_W = 12;
	localparam int COUNT_W = 13;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// default sizing
	localparam int DEF_TABLE_DEPTH = 4096;
	localparam int DEF_MAX_MATCHES = 16;

	// item function codes
	typedef enum logic [0:0] {
		FUNC_LOAD   = 1'b0,
		FUNC_SEARCH = 1'b1
	} func_t;

	// register indexes
	typedef enum logic [0:0] {
		REG_ENTRY_COUNT = 1'b0,
		REG_DATA_OFFSET = 1'b1
	} reg_idx_t;

	// one table entry as stored
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	// configuration seen by the search control
	typedef struct packed {
		logic [COUNT_W-1:0] entry_count;
		logic [ADDR_W-1:0]  data_offset;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/sksr_if.sv
// request and result channel interfaces
`default_nettype none

interface sksr_in_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [sksr_pkg::INDEX_W-1:0] entry_index;
	logic [sksr_pkg::CODE_W-1:0]  entry_code;
	logic [sksr_pkg::SIZE_W-1:0]  entry_size;
	logic [sksr_pkg::ADDR_W-1:0]  entry_address;
	logic [sksr_pkg::CODE_W-1:0]  search_key;

	modport source (
		output valid, func, entry_index, entry_code, entry_size, entry_address, search_key,
		input  ready
	);
	modport sink (
		input  valid, func, entry_index, entry_code, entry_size, entry_address, search_key,
		output ready
	);
endinterface

interface sksr_out_if #(
	parameter int CNT_W = 5
);
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [CNT_W-1:0]             match_count;
	logic [sksr_pkg::INDEX_W-1:0] entry_position;
	logic [sksr_pkg::ADDR_W-1:0]  record_address;
	logic [sksr_pkg::SIZE_W-1:0]  record_size;
	logic                         last;

	modport source (
		output valid, found, match_count, entry_position, record_address, record_size, last,
		input  ready
	);
	modport sink (
		input  valid, found, match_count, entry_position, record_address, record_size, last,
		output ready
	);
endinterface

`default_nettype wire

### rtl/sksr_mem.sv
// entry table: one write port, one read port with registered read data
`default_nettype none

module sksr_mem #(
	parameter int TABLE_DEPTH = sksr_pkg::DEF_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire sksr_pkg::entry_t wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output sksr_pkg::entry_t      rd_data
);

	sksr_pkg::entry_t mem_q [TABLE_DEPTH];
	sksr_pkg::entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/sksr_cfg.sv
// configuration registers behind the apb port
`default_nettype none

module sksr_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sksr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sksr_pkg::PDATA_W-1:0] pwdata,
	output logic      [sksr_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	output sksr_pkg::cfg_t                    cfg
);

	logic [sksr_pkg::COUNT_W-1:0] entry_count_q;
	logic [sksr_pkg::ADDR_W-1:0]  data_offset_q;
	sksr_pkg::reg_idx_t           reg_idx;
	logic                         wr_stb;

	assign reg_idx = sksr_pkg::reg_idx_t'(paddr[2]);
	assign wr_stb  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			data_offset_q <= '0;
		end else if (wr_stb) begin
			case (reg_idx)
				sksr_pkg::REG_ENTRY_COUNT: entry_count_q <= pwdata[sksr_pkg::COUNT_W-1:0];
				sksr_pkg::REG_DATA_OFFSET: data_offset_q <= pwdata[sksr_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			sksr_pkg::REG_ENTRY_COUNT: prdata = sksr_pkg::PDATA_W'(entry_count_q);
			sksr_pkg::REG_DATA_OFFSET: prdata = sksr_pkg::PDATA_W'(data_offset_q);
			default:                   prdata = '0;
		endcase
	end

	assign cfg.entry_count = entry_count_q;
	assign cfg.data_offset = data_offset_q;

endmodule

`default_nettype wire

### rtl/sksr_ctrl.sv
// search sequencer: binary search, run widening and result emission over the table
`default_nettype none

module sksr_ctrl #(
	parameter int TABLE_DEPTH = sksr_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_MATCHES = sksr_pkg::DEF_MAX_MATCHES,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int NW = $clog2(TABLE_DEPTH + 1),
	localparam int CW = $clog2(MAX_MATCHES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	sksr_in_if.sink               item,
	sksr_out_if.source            result,
	input  wire sksr_pkg::cfg_t   cfg,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output sksr_pkg::entry_t      wr_data,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  wire sksr_pkg::entry_t rd_data
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SRCH    = 8'b0000_0010,
		ST_DOWN    = 8'b0000_0100,
		ST_UP_CHK  = 8'b0000_1000,
		ST_UP      = 8'b0001_0000,
		ST_EMIT_ST = 8'b0010_0000,
		ST_EMIT    = 8'b0100_0000,
		ST_MISS    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// search window [low, hi), probe, run bounds and emit counters
	logic [NW-1:0]                lo_q, lo_d, hi_q, hi_d, n_q, n_d, run_q, run_d;
	logic [AW-1:0]                mid_q, mid_d, beg_q, beg_d, end_q, end_d, pos_q, pos_d;
	logic [CW-1:0]                cnt_q, cnt_d, k_q, k_d;
	logic [sksr_pkg::CODE_W-1:0]  key_q, key_d;

	// output register
	logic                         out_valid_q;
	logic                         out_load;
	logic                         out_found_d, out_last_d;
	logic [CW-1:0]                out_cnt_d;
	logic [sksr_pkg::INDEX_W-1:0] out_pos_d;
	logic [sksr_pkg::ADDR_W-1:0]  out_addr_d;
	logic [sksr_pkg::SIZE_W-1:0]  out_size_d;
	logic                         out_found_q, out_last_q;
	logic [CW-1:0]                out_cnt_q;
	logic [sksr_pkg::INDEX_W-1:0] out_pos_q;
	logic [sksr_pkg::ADDR_W-1:0]  out_addr_q;
	logic [sksr_pkg::SIZE_W-1:0]  out_size_q;

	logic                         out_free;
	logic                         in_acc;
	logic [NW-1:0]                n_clamp;
	logic [NW-1:0]                nlo, nhi;
	logic [NW:0]                  mid_sum;
	logic                         code_eq, key_lt;

	assign in_acc   = item.valid & item.ready;
	assign out_free = ~out_valid_q | result.ready;
	assign item.ready = (state_q == ST_IDLE);

	// table size limited to the depth
	assign n_clamp = (32'(cfg.entry_count) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
	                                                           : NW'(cfg.entry_count);

	assign code_eq = (rd_data.code == key_q);
	assign key_lt  = (key_q < rd_data.code);

	// load write path
	always_comb begin
		wr_en        = in_acc && (item.func == sksr_pkg::FUNC_LOAD)
		               && (32'(item.entry_index) < 32'(TABLE_DEPTH));
		wr_addr      = AW'(item.entry_index);
		wr_data.code = item.entry_code;
		wr_data.size = item.entry_size;
		wr_data.addr = item.entry_address;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		n_d     = n_q;
		run_d   = run_q;
		mid_d   = mid_q;
		beg_d   = beg_q;
		end_d   = end_q;
		pos_d   = pos_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		key_d   = key_q;
		rd_en   = 1'b0;
		rd_addr = mid_q;
		nlo     = lo_q;
		nhi     = hi_q;
		mid_sum = '0;

		out_load    = 1'b0;
		out_found_d = 1'b0;
		out_last_d  = 1'b1;
		out_cnt_d   = '0;
		out_pos_d   = '0;
		out_addr_d  = '0;
		out_size_d  = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_acc && (item.func == sksr_pkg::FUNC_SEARCH)) begin
					key_d   = item.search_key;
					n_d     = n_clamp;
					lo_d    = '0;
					hi_d    = n_clamp;
					mid_sum = {1'b0, n_clamp} - 1'b1;
					mid_d   = AW'(mid_sum >> 1);
					if (n_clamp == '0) begin
						state_d = ST_MISS;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(mid_sum >> 1);
						state_d = ST_SRCH;
					end
				end
			end

			// probe data for mid_q is back
			ST_SRCH: begin
				if (code_eq) begin
					beg_d = mid_q;
					end_d = mid_q;
					run_d = NW'(1);
					if (mid_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = mid_q - 1'b1;
						state_d = ST_DOWN;
					end else begin
						state_d = ST_UP_CHK;
					end
				end else begin
					if (key_lt) begin
						nlo = lo_q;
						nhi = NW'(mid_q);
					end else begin
						nlo = NW'(mid_q) + 1'b1;
						nhi = hi_q;
					end
					lo_d    = nlo;
					hi_d    = nhi;
					mid_sum = {1'b0, nlo} + {1'b0, nhi} - 1'b1;
					mid_d   = AW'(mid_sum >> 1);
					if (nlo < nhi) begin
						rd_en   = 1'b1;
						rd_addr = AW'(mid_sum >> 1);
					end else begin
						state_d = ST_MISS;
					end
				end
			end

			// entry below the run start is back
			ST_DOWN: begin
				if (code_eq) begin
					beg_d = beg_q - 1'b1;
					run_d = run_q + 1'b1;
					if (beg_q != AW'(1)) begin
						rd_en   = 1'b1;
						rd_addr = beg_q - AW'(2);
					end else begin
						state_d = ST_UP_CHK;
					end
				end else begin
					state_d = ST_UP_CHK;
				end
			end

			// extend upward while inside the table and under the cap
			ST_UP_CHK: begin
				if (((NW+1)'(end_q) + 1'b1 < (NW+1)'(n_q)) &&
				    (32'(run_q) < 32'(MAX_MATCHES))) begin
					rd_en   = 1'b1;
					rd_addr = end_q + 1'b1;
					state_d = ST_UP;
				end else begin
					state_d = ST_EMIT_ST;
				end
			end

			ST_UP: begin
				if (code_eq) begin
					end_d   = end_q + 1'b1;
					run_d   = run_q + 1'b1;
					state_d = ST_UP_CHK;
				end else begin
					state_d = ST_EMIT_ST;
				end
			end

			// fix the count and fetch the first match
			ST_EMIT_ST: begin
				cnt_d   = (32'(run_q) >= 32'(MAX_MATCHES)) ? CW'(MAX_MATCHES) : CW'(run_q);
				k_d     = '0;
				pos_d   = beg_q;
				rd_en   = 1'b1;
				rd_addr = beg_q;
				state_d = ST_EMIT;
			end

			// one word per cycle while the output register has room
			ST_EMIT: begin
				out_found_d = 1'b1;
				out_cnt_d   = cnt_q;
				out_pos_d   = sksr_pkg::INDEX_W'(pos_q);
				out_addr_d  = rd_data.addr + cfg.data_offset;
				out_size_d  = rd_data.size;
				out_last_d  = ((k_q + 1'b1) == cnt_q);
				if (out_free) begin
					out_load = 1'b1;
					if ((k_q + 1'b1) == cnt_q) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + 1'b1;
						pos_d   = pos_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = pos_q + 1'b1;
					end
				end
			end

			ST_MISS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		n_q   <= n_d;
		run_q <= run_d;
		mid_q <= mid_d;
		beg_q <= beg_d;
		end_q <= end_d;
		pos_q <= pos_d;
		cnt_q <= cnt_d;
		k_q   <= k_d;
		key_q <= key_d;
		if (out_load) begin
			out_found_q <= out_found_d;
			out_cnt_q   <= out_cnt_d;
			out_pos_q   <= out_pos_d;
			out_addr_q  <= out_addr_d;
			out_size_q  <= out_size_d;
			out_last_q  <= out_last_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.found          = out_found_q;
	assign result.match_count    = out_cnt_q;
	assign result.entry_position = out_pos_q;
	assign result.record_address = out_addr_q;
	assign result.record_size    = out_size_q;
	assign result.last           = out_last_q;

endmodule

`default_nettype wire

### rtl/sorted_key_equal_range_search.sv
// top level of the sorted key equal range search block
//
// The item channel carries loads and queries. A load (func 0) writes one
// table entry at entry_index in the accept cycle and gives no result; a load
// beyond the table depth is dropped. A query (func 1) binary searches the
// first entry_count entries for search_key, walks down to the lowest equal
// entry, counts up to MAX_MATCHES equal entries, then streams one result word
// per match, lowest position first, with last set on the final word. A miss
// gives one word with found clear.
// A query reads the entry table through its registered read port. After the
// accept cycle it runs the binary search probes, reads entries below the hit
// and then above it, then fetches and streams the match words; the downward
// walk is not capped by MAX_MATCHES. One item is in work at a time; item
// ready is high only while the sequencer is idle, and it may accept the next
// item while the final result word still sits in the output register.
// A stalled result channel holds the output register and the sequencer waits.
// Reset clears the sequencer, the output valid and both registers; the table
// is not cleared and must be loaded before it is searched.
`default_nettype none

module sorted_key_equal_range_search #(
	parameter int TABLE_DEPTH = sksr_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_MATCHES = sksr_pkg::DEF_MAX_MATCHES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	sksr_in_if.sink                           item,
	sksr_out_if.source                        result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sksr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sksr_pkg::PDATA_W-1:0] pwdata,
	output logic      [sksr_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);

	localparam int AW = $clog2(TABLE_DEPTH);

	sksr_pkg::cfg_t   cfg;
	logic             wr_en, rd_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	sksr_pkg::entry_t wr_data, rd_data;

	// configuration registers
	sksr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// search sequencer
	sksr_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_MATCHES (MAX_MATCHES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.cfg     (cfg),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// entry table
	sksr_mem #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

### rtl/sksr_checker.sv
// port level checks of the search block and their binding
`default_nettype none
`include "assert_macros.svh"

module sksr_checker #(
	parameter int MAX_MATCHES = sksr_pkg::DEF_MAX_MATCHES,
	localparam int CW = $clog2(MAX_MATCHES + 1)
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         item_valid,
	input wire logic                         item_ready,
	input wire logic                         item_func,
	input wire logic                         res_valid,
	input wire logic                         res_ready,
	input wire logic                         res_found,
	input wire logic [CW-1:0]                res_count,
	input wire logic [sksr_pkg::INDEX_W-1:0] res_pos,
	input wire logic [sksr_pkg::ADDR_W-1:0]  res_addr,
	input wire logic [sksr_pkg::SIZE_W-1:0]  res_size,
	input wire logic                         res_last
);

	// a stalled word keeps its contents
	`SKSR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_found) && $stable(res_count) && $stable(res_pos) && $stable(res_addr) && $stable(res_size) && $stable(res_last), "stalled result word changed")

	// a miss is a single empty word
	`SKSR_ASSERT_SAME(a_miss_shape, clk, arst_n, res_valid && !res_found, res_last && (res_count == '0) && (res_pos == '0) && (res_addr == '0) && (res_size == '0), "miss word malformed")

	// a hit reports a count within the cap
	`SKSR_ASSERT_SAME(a_hit_count, clk, arst_n, res_valid && res_found, (res_count != '0) && (32'(res_count) <= 32'(MAX_MATCHES)), "hit count out of range")

	// a query occupies the sequencer for at least the next cycle
	`SKSR_ASSERT_NEXT(a_query_busy, clk, arst_n, item_valid && item_ready && (item_func == sksr_pkg::FUNC_SEARCH), !item_ready, "item accepted during a query")

endmodule

bind sorted_key_equal_range_search sksr_checker #(
	.MAX_MATCHES (MAX_MATCHES)
) u_sksr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_func  (item.func),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_found  (result.found),
	.res_count  (result.match_count),
	.res_pos    (result.entry_position),
	.res_addr   (result.record_address),
	.res_size   (result.record_size),
	.res_last   (result.last)
);

`default_nettype wire
